>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the transform unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Next-cycle implication that stays active through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("reset check failed");

`endif

>>> design/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg
// Widths, constants and types of the 4x4 matrix vector transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int ELEM_W     = 32;
   localparam int VEC_LEN    = 4;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int PAIR_W     = PROD_W + 1;
   localparam int SUM_W      = PROD_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 2 * ELEM_W;
   // Register stages of every row datapath, one per field of stage_en_type.
   localparam int NUM_STAGES = 4;

   typedef logic [ELEM_W-1:0]              elem_type;
   typedef logic [VEC_LEN-1:0][ELEM_W-1:0] quad_type;

   localparam elem_type ELEM_ONE = elem_type'(1) << FRAC_BITS;
   localparam elem_type ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam elem_type ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   // Load enables of the four pipeline stages.
   typedef struct packed {
      logic load_prod;
      logic load_pair;
      logic load_sum;
      logic load_out;
   } stage_en_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW0_COLS01,
      REG_ROW0_COLS23,
      REG_ROW1_COLS01,
      REG_ROW1_COLS23,
      REG_ROW2_COLS01,
      REG_ROW2_COLS23,
      REG_ROW3_COLS01,
      REG_ROW3_COLS23
   } csr_index_type;

endpackage

`default_nettype wire

>>> design/mvt_req_if.sv
// ----------------------------------------------------------------------------
// mvt_req_if
// Input vector channel of the transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvt_req_if;
   logic             valid;
   logic             ready;
   mvt_pkg::elem_type vec_x;
   mvt_pkg::elem_type vec_y;
   mvt_pkg::elem_type vec_z;
   mvt_pkg::elem_type vec_w;

   modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                   input ready);
   modport sink   (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                   output ready);
endinterface

`default_nettype wire

>>> design/mvt_rsp_if.sv
// ----------------------------------------------------------------------------
// mvt_rsp_if
// Result vector channel of the transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvt_rsp_if;
   logic             valid;
   logic             ready;
   mvt_pkg::elem_type out_x;
   mvt_pkg::elem_type out_y;
   mvt_pkg::elem_type out_z;
   mvt_pkg::elem_type out_w;
   logic             saturated;

   modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                   output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                   input saturated, output ready);
endinterface

`default_nettype wire

>>> design/matrix4_vector_transform_unit.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform_unit
// Multiplies a stream of four-element Q16.16 vectors by a configurable 4x4
// matrix with exact accumulation, arithmetic shift and 32-bit saturation.
// ----------------------------------------------------------------------------
// The unit accepts one vector transaction per clock cycle unless a stall at
// the result side backs up to it, and delivers results in order through the
// four register stages of every row datapath: the four 32x32 products, the
// pairwise sums, the full 66-bit row sum, and the shift-and-saturate stage
// whose register drives the result channel. Each stage holds its contents
// while the stage after it is full and stalled, so bubbles are squeezed out
// and a new transaction is taken whenever the first stage can advance; the
// input ready follows the result ready combinationally through that chain.
// The matrix resets to identity and is written through the csr_ port, two
// elements per 64-bit register: the even column in the low half, the odd
// column in the high half. Write the matrix only while no transaction is in
// flight. The saturated flag is set when any of the four outputs was clamped.
`default_nettype none

`include "assert_macros.svh"

module matrix4_vector_transform_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   mvt_req_if.sink                               req_bus,
   mvt_rsp_if.source                             rsp_bus,
   input  wire                                   csr_write_en,
   input  wire [mvt_pkg::CSR_IDX_W-1:0]          csr_index,
   input  wire [mvt_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   // Matrix storage, one quad of elements per row.
   mvt_pkg::quad_type     mat_ff [mvt_pkg::VEC_LEN];

   // One valid bit per pipeline stage; the last one is the result valid.
   logic [mvt_pkg::NUM_STAGES-1:0] valid_ff;
   logic [mvt_pkg::NUM_STAGES-1:0] valid_in;
   mvt_pkg::stage_en_type stage_en;

   mvt_pkg::quad_type     req_vec;
   mvt_pkg::elem_type     row_result [mvt_pkg::VEC_LEN];
   logic [mvt_pkg::VEC_LEN-1:0] row_sat;
   logic                  clamp_seen;

   // Matrix configuration. Reset loads the identity matrix.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < mvt_pkg::VEC_LEN; r++) begin
            for (int c = 0; c < mvt_pkg::VEC_LEN; c++) begin
               mat_ff[r][c] <= (r == c) ? mvt_pkg::ELEM_ONE : '0;
            end
         end
      end else if (csr_write_en) begin
         unique case (mvt_pkg::csr_index_type'(csr_index))
            mvt_pkg::REG_ROW0_COLS01: begin
               mat_ff[0][0] <= csr_wdata[mvt_pkg::ELEM_W-1:0];
               mat_ff[0][1] <= csr_wdata[mvt_pkg::CSR_DATA_W-1:mvt_pkg::ELEM_W];
            end
            mvt_pkg::REG_ROW0_COLS23: begin
               mat_ff[0][2] <= csr_wdata[mvt_pkg::ELEM_W-1:0];
               mat_ff[0][3] <= csr_wdata[mvt_pkg::CSR_DATA_W-1:mvt_pkg::ELEM_W];
            end
            mvt_pkg::REG_ROW1_COLS01: begin
               mat_ff[1][0] <= csr_wdata[mvt_pkg::ELEM_W-1:0];
               mat_ff[1][1] <= csr_wdata[mvt_pkg::CSR_DATA_W-1:mvt_pkg::ELEM_W];
            end
            mvt_pkg::REG_ROW1_COLS23: begin
               mat_ff[1][2] <= csr_wdata[mvt_pkg::ELEM_W-1:0];
               mat_ff[1][3] <= csr_wdata[mvt_pkg::CSR_DATA_W-1:mvt_pkg::ELEM_W];
            end
            mvt_pkg::REG_ROW2_COLS01: begin
               mat_ff[2][0] <= csr_wdata[mvt_pkg::ELEM_W-1:0];
               mat_ff[2][1] <= csr_wdata[mvt_pkg::CSR_DATA_W-1:mvt_pkg::ELEM_W];
            end
            mvt_pkg::REG_ROW2_COLS23: begin
               mat_ff[2][2] <= csr_wdata[mvt_pkg::ELEM_W-1:0];
               mat_ff[2][3] <= csr_wdata[mvt_pkg::CSR_DATA_W-1:mvt_pkg::ELEM_W];
            end
            mvt_pkg::REG_ROW3_COLS01: begin
               mat_ff[3][0] <= csr_wdata[mvt_pkg::ELEM_W-1:0];
               mat_ff[3][1] <= csr_wdata[mvt_pkg::CSR_DATA_W-1:mvt_pkg::ELEM_W];
            end
            mvt_pkg::REG_ROW3_COLS23: begin
               mat_ff[3][2] <= csr_wdata[mvt_pkg::ELEM_W-1:0];
               mat_ff[3][3] <= csr_wdata[mvt_pkg::CSR_DATA_W-1:mvt_pkg::ELEM_W];
            end
            default: begin
            end
         endcase
      end
   end

   // A stage loads when it is empty or when the stage after it moves on.
   // The last stage moves on when the consumer takes the transaction.
   always_comb begin
      stage_en.load_out  = !valid_ff[3] || rsp_bus.ready;
      stage_en.load_sum  = !valid_ff[2] || stage_en.load_out;
      stage_en.load_pair = !valid_ff[1] || stage_en.load_sum;
      stage_en.load_prod = !valid_ff[0] || stage_en.load_pair;

      valid_in[0] = stage_en.load_prod ? req_bus.valid : valid_ff[0];
      valid_in[1] = stage_en.load_pair ? valid_ff[0]   : valid_ff[1];
      valid_in[2] = stage_en.load_sum  ? valid_ff[1]   : valid_ff[2];
      valid_in[3] = stage_en.load_out  ? valid_ff[2]   : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_bus.ready = stage_en.load_prod;
   assign req_vec       = {req_bus.vec_w, req_bus.vec_z, req_bus.vec_y, req_bus.vec_x};

   // One datapath per matrix row; all four share the stage enables.
   for (genvar r = 0; r < mvt_pkg::VEC_LEN; r++) begin : g_row
      mvt_row_pipe u_row (
         .clock    (clock),
         .stage_en (stage_en),
         .row      (mat_ff[r]),
         .vec      (req_vec),
         .result   (row_result[r]),
         .sat      (row_sat[r])
      );
   end

   assign rsp_bus.valid     = valid_ff[3];
   assign rsp_bus.out_x     = row_result[0];
   assign rsp_bus.out_y     = row_result[1];
   assign rsp_bus.out_z     = row_result[2];
   assign rsp_bus.out_w     = row_result[3];
   assign rsp_bus.saturated = |row_sat;

   // True when at least one output sits at a saturation limit.
   always_comb begin
      clamp_seen = 1'b0;
      for (int r = 0; r < mvt_pkg::VEC_LEN; r++) begin
         if (row_result[r] == mvt_pkg::ELEM_MAX || row_result[r] == mvt_pkg::ELEM_MIN) begin
            clamp_seen = 1'b1;
         end
      end
   end

   // Reset empties the whole pipeline.
   `ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, valid_ff == '0)
   // A full sum stage that is allowed to advance produces a result next cycle.
   `ASSERT_NEXT(a_sum_to_out, clock, reset, valid_ff[2] && stage_en.load_out, rsp_bus.valid)
   // A stalled result keeps the transaction behind it in the sum stage.
   `ASSERT_NEXT(a_stall_holds_sum, clock, reset, valid_ff[2] && valid_ff[3] && !rsp_bus.ready, valid_ff[2])
   // A saturated result always carries at least one clamped element.
   `ASSERT_IMPLY(a_sat_clamped, clock, reset, rsp_bus.valid && rsp_bus.saturated, clamp_seen)

endmodule

`default_nettype wire

>>> design/mvt_row_pipe.sv
// ----------------------------------------------------------------------------
// mvt_row_pipe
// Four-stage datapath of one matrix row: multiply, pair add, final add,
// shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_row_pipe (
   input  wire                        clock,
   input  wire mvt_pkg::stage_en_type stage_en,
   input  wire mvt_pkg::quad_type     row,
   input  wire mvt_pkg::quad_type     vec,
   output mvt_pkg::elem_type          result,
   output logic                       sat
);

   logic signed [mvt_pkg::PROD_W-1:0] prod_ff [mvt_pkg::VEC_LEN];
   logic signed [mvt_pkg::PROD_W-1:0] prod_in [mvt_pkg::VEC_LEN];
   logic signed [mvt_pkg::PAIR_W-1:0] pair_ff [2];
   logic signed [mvt_pkg::SUM_W-1:0]  sum_ff;
   logic signed [mvt_pkg::SUM_W-1:0]  shifted;
   logic [mvt_pkg::SUM_W-mvt_pkg::ELEM_W:0] upper;
   logic                              fits;
   mvt_pkg::elem_type                 result_in;
   mvt_pkg::elem_type                 result_ff;
   logic                              sat_in;
   logic                              sat_ff;

   // Both factors are sign extended to the product width, so the multiply is
   // a signed 32x32 one with a full 64-bit result.
   always_comb begin
      for (int j = 0; j < mvt_pkg::VEC_LEN; j++) begin
         prod_in[j] = mvt_pkg::PROD_W'($signed(row[j])) *
                      mvt_pkg::PROD_W'($signed(vec[j]));
      end
   end

   // The sum is exact; the shifted value fits when all bits from the output
   // sign bit upward agree.
   assign shifted = sum_ff >>> mvt_pkg::FRAC_BITS;
   assign upper   = shifted[mvt_pkg::SUM_W-1:mvt_pkg::ELEM_W-1];
   assign fits    = (&upper) || !(|upper);

   always_comb begin
      if (fits) begin
         result_in = shifted[mvt_pkg::ELEM_W-1:0];
      end else if (shifted[mvt_pkg::SUM_W-1]) begin
         result_in = mvt_pkg::ELEM_MIN;
      end else begin
         result_in = mvt_pkg::ELEM_MAX;
      end
      sat_in = !fits;
   end

   always_ff @(posedge clock) begin
      if (stage_en.load_prod) begin
         for (int j = 0; j < mvt_pkg::VEC_LEN; j++) begin
            prod_ff[j] <= prod_in[j];
         end
      end
      if (stage_en.load_pair) begin
         pair_ff[0] <= mvt_pkg::PAIR_W'(prod_ff[0]) + mvt_pkg::PAIR_W'(prod_ff[1]);
         pair_ff[1] <= mvt_pkg::PAIR_W'(prod_ff[2]) + mvt_pkg::PAIR_W'(prod_ff[3]);
      end
      if (stage_en.load_sum) begin
         sum_ff <= mvt_pkg::SUM_W'(pair_ff[0]) + mvt_pkg::SUM_W'(pair_ff[1]);
      end
      if (stage_en.load_out) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

`default_nettype wire

>>> verif/tb_matrix4_vector_transform_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix4_vector_transform_unit
// Self-checking bench for the 4x4 matrix vector transform unit: a bit-exact
// Q16.16 predictor runs alongside the block under randomized flow control.
// ----------------------------------------------------------------------------

module tb_matrix4_vector_transform_unit;

   // Idle cycles after the final drain cover the settle time at the very
   // end of the run.
   localparam int DRAIN_CYCLES = 10;
   // Roughly 1300 transactions with random sender gaps and receiver stalls,
   // plus the long hold-off: this is many times the need.
   localparam int LIMIT_CYCLES = 400000;
   localparam int IDLE_PERCENT = 23;

   typedef mvt_pkg::elem_type vec4_type [mvt_pkg::VEC_LEN];
   typedef logic [mvt_pkg::CSR_DATA_W-1:0] matrix_regs_type [8];

   // One transformed vector as the result channel carries it.
   typedef struct packed {
      mvt_pkg::elem_type x;
      mvt_pkg::elem_type y;
      mvt_pkg::elem_type z;
      mvt_pkg::elem_type w;
      logic              saturated;
   } vector_result_type;

   logic clock;
   logic reset;
   logic                           csr_write_en;
   logic [mvt_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mvt_pkg::CSR_DATA_W-1:0] csr_wdata;

   mvt_req_if req_bus ();
   mvt_rsp_if rsp_bus ();

   matrix4_vector_transform_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // The bench's own copy of the matrix, updated at the edge of each write.
   matrix_regs_type   matrix_regs;
   // Transformed vectors still owed by the block, oldest first.
   vector_result_type results_in_flight [$];

   int error_count     = 0;
   int cycle_count     = 0;
   // When set, neither side inserts random idle cycles.
   bit no_idling       = 1'b0;
   // Number of cycles the result side refuses every transaction.
   int rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // One matrix row dotted with the vector. The four full 64-bit products are
   // summed exactly, shifted arithmetically (which rounds toward minus
   // infinity) and clamped to 32 bits. The top bit of the return value tells
   // whether the clamp was needed.
   function automatic logic [mvt_pkg::ELEM_W:0] row_dot(
         input logic [mvt_pkg::CSR_DATA_W-1:0] cols01,
         input logic [mvt_pkg::CSR_DATA_W-1:0] cols23,
         input vec4_type v);
      mvt_pkg::elem_type   coef [mvt_pkg::VEC_LEN];
      logic signed [63:0]  prod;
      logic signed [127:0] acc;
      coef[0] = cols01[31:0];
      coef[1] = cols01[63:32];
      coef[2] = cols23[31:0];
      coef[3] = cols23[63:32];
      acc = '0;
      for (int k = 0; k < mvt_pkg::VEC_LEN; k++) begin
         prod = 64'($signed(coef[k])) * 64'($signed(v[k]));
         acc  = acc + 128'(prod);
      end
      acc = acc >>> mvt_pkg::FRAC_BITS;
      if (acc > 128'sh7FFF_FFFF)
         return {1'b1, mvt_pkg::ELEM_MAX};
      else if (acc < -128'sh8000_0000)
         return {1'b1, mvt_pkg::ELEM_MIN};
      else
         return {1'b0, acc[mvt_pkg::ELEM_W-1:0]};
   endfunction

   // Full transform of one vector with the matrix as it currently stands.
   function automatic vector_result_type transform_vector(input vec4_type v);
      logic [mvt_pkg::ELEM_W:0] rows [mvt_pkg::VEC_LEN];
      vector_result_type        res;
      for (int r = 0; r < mvt_pkg::VEC_LEN; r++)
         rows[r] = row_dot(matrix_regs[2*r], matrix_regs[2*r+1], v);
      res.x         = rows[0][mvt_pkg::ELEM_W-1:0];
      res.y         = rows[1][mvt_pkg::ELEM_W-1:0];
      res.z         = rows[2][mvt_pkg::ELEM_W-1:0];
      res.w         = rows[3][mvt_pkg::ELEM_W-1:0];
      res.saturated = rows[0][mvt_pkg::ELEM_W] | rows[1][mvt_pkg::ELEM_W] |
                      rows[2][mvt_pkg::ELEM_W] | rows[3][mvt_pkg::ELEM_W];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Value generators
   // ------------------------------------------------------------------------

   // A mix of corner values, full-range noise and modest fixed-point values,
   // so that both clean results and saturation show up regularly.
   function automatic mvt_pkg::elem_type pick_value();
      mvt_pkg::elem_type v;
      int unsigned       sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         case ($urandom_range(0, 6))
            0:       v = mvt_pkg::ELEM_MAX;
            1:       v = mvt_pkg::ELEM_MIN;
            2:       v = '0;
            3:       v = mvt_pkg::elem_type'(1);
            4:       v = '1;
            5:       v = mvt_pkg::ELEM_ONE;
            default: v = -mvt_pkg::ELEM_ONE;
         endcase
      end else if (sel <= 3) begin
         v = $urandom;
      end else begin
         v = $urandom_range(0, (1 << $urandom_range(4, 22)) - 1);
         if ($urandom_range(0, 1))
            v = -v;
      end
      return v;
   endfunction

   function automatic matrix_regs_type fill_matrix(input mvt_pkg::elem_type e);
      matrix_regs_type m;
      foreach (m[i])
         m[i] = {e, e};
      return m;
   endfunction

   // Kind 0 mixes corners and noise, kind 1 is pure noise, kind 2 keeps
   // every element within plus or minus 4.0.
   function automatic matrix_regs_type random_matrix(input int kind);
      matrix_regs_type   m;
      mvt_pkg::elem_type lo, hi;
      foreach (m[i]) begin
         case (kind)
            0: begin
               lo = pick_value();
               hi = pick_value();
            end
            1: begin
               lo = $urandom;
               hi = $urandom;
            end
            default: begin
               lo = $urandom_range(0, 4 << mvt_pkg::FRAC_BITS);
               hi = $urandom_range(0, 4 << mvt_pkg::FRAC_BITS);
               if ($urandom_range(0, 1))
                  lo = -lo;
               if ($urandom_range(0, 1))
                  hi = -hi;
            end
         endcase
         m[i] = {hi, lo};
      end
      return m;
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Offers one vector and waits for the handshake. Valid is left high after
   // acceptance so that back-to-back transactions need no extra edge; every
   // caller that stops sending lowers it through wait_drained.
   task automatic send_vector(input mvt_pkg::elem_type x, input mvt_pkg::elem_type y,
                              input mvt_pkg::elem_type z, input mvt_pkg::elem_type w);
      vec4_type v;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      v[3] = w;
      while (!no_idling && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.vec_x <= x;
      req_bus.vec_y <= y;
      req_bus.vec_z <= z;
      req_bus.vec_w <= w;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      results_in_flight.push_back(transform_vector(v));
   endtask

   task automatic send_random_vector();
      send_vector(pick_value(), pick_value(), pick_value(), pick_value());
   endtask

   // Stops offering and waits until every owed result has been checked.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (results_in_flight.size() != 0)
         @(posedge clock);
   endtask

   // Writes all eight matrix registers on consecutive edges. The block is
   // idle whenever this runs, so the bench copy can follow each write edge.
   task automatic program_matrix(input matrix_regs_type m);
      for (int i = 0; i < 8; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= mvt_pkg::csr_index_type'(i);
         csr_wdata    <= m[i];
         @(posedge clock);
         matrix_regs[i] = m[i];
      end
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result side: flow control and checking
   // ------------------------------------------------------------------------

   // The hold-off counter is consumed here, one cycle per edge, so a test
   // only has to set it and keep sending.
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else if (no_idling) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   task automatic compare_field(input string field,
                                input logic [mvt_pkg::ELEM_W-1:0] want,
                                input logic [mvt_pkg::ELEM_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Every transaction on the result channel is matched against the oldest
   // owed vector, field by field.
   always @(posedge clock) begin
      vector_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (results_in_flight.size() == 0) begin
            $display("%0t: result transaction with nothing owed, actual %h %h %h %h %b",
                     $time, rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_z, rsp_bus.out_w,
                     rsp_bus.saturated);
            error_count++;
         end else begin
            want = results_in_flight.pop_front();
            compare_field("out_x", want.x, rsp_bus.out_x);
            compare_field("out_y", want.y, rsp_bus.out_y);
            compare_field("out_z", want.z, rsp_bus.out_z);
            compare_field("out_w", want.w, rsp_bus.out_w);
            compare_field("saturated", mvt_pkg::ELEM_W'(want.saturated),
                          mvt_pkg::ELEM_W'(rsp_bus.saturated));
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // The matrix comes out of reset as identity, so every vector, corners
   // included, must pass through unchanged and unclamped.
   task automatic test_identity_after_reset();
      send_vector('0, '0, '0, '0);
      send_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_ONE,
                  -mvt_pkg::ELEM_ONE);
      send_vector(mvt_pkg::elem_type'(1), '1, 32'h1234_5678, 32'h8765_4321);
      send_vector(mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MIN,
                  mvt_pkg::ELEM_MAX);
      wait_drained();
   endtask

   // Largest-magnitude matrices: extreme vectors push the row sums far past
   // 32 bits in both directions and must clamp; the others must not.
   task automatic test_saturation_extremes();
      program_matrix(fill_matrix(mvt_pkg::ELEM_MIN));
      send_vector(mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN,
                  mvt_pkg::ELEM_MIN);
      send_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX,
                  mvt_pkg::ELEM_MAX);
      send_vector('0, '0, '0, '0);
      send_vector(mvt_pkg::elem_type'(1), '0, '0, '0);
      wait_drained();
      program_matrix(fill_matrix(mvt_pkg::ELEM_MAX));
      send_vector(mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN,
                  mvt_pkg::ELEM_MIN);
      send_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX,
                  mvt_pkg::ELEM_MAX);
      send_vector(mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MAX,
                  mvt_pkg::ELEM_MIN);
      wait_drained();
   endtask

   // Sparse matrix aimed at the edges of the 32-bit range and at rounding:
   // row 0 doubles x, row 1 scales x by the smallest step, row 2 doubles y
   // and row 3 negates w. A sum of exactly +2^31 must clamp, exactly -2^31
   // must not, and tiny negative products round down to minus one LSB.
   task automatic test_rounding_boundaries();
      matrix_regs_type m;
      m = fill_matrix('0);
      m[mvt_pkg::REG_ROW0_COLS01] = {32'h0, 2 * mvt_pkg::ELEM_ONE};
      m[mvt_pkg::REG_ROW1_COLS01] = {32'h0, mvt_pkg::elem_type'(1)};
      m[mvt_pkg::REG_ROW2_COLS01] = {2 * mvt_pkg::ELEM_ONE, 32'h0};
      m[mvt_pkg::REG_ROW3_COLS23] = {-mvt_pkg::ELEM_ONE, 32'h0};
      program_matrix(m);
      send_vector(32'h4000_0000, 32'h3FFF_FFFF, 32'h0, mvt_pkg::ELEM_MIN);
      send_vector(32'hC000_0000, 32'hC000_0000, 32'h0, mvt_pkg::ELEM_MAX);
      send_vector('1, 32'h3FFF_FFFF, mvt_pkg::ELEM_MAX, 32'h8000_0001);
      send_vector(32'h0000_FFFF, 32'hBFFF_FFFF, mvt_pkg::ELEM_MIN, '0);
      send_vector(32'hFFFF_0000, 32'h4000_0000, mvt_pkg::ELEM_ONE, '1);
      wait_drained();
   endtask

   // Several random matrices, each followed by a burst of random vectors.
   // One phase runs with no idle cycles on either side.
   task automatic test_random_matrices();
      for (int phase = 0; phase < 9; phase++) begin
         program_matrix(random_matrix(phase % 3));
         no_idling = (phase == 4);
         repeat (130)
            send_random_vector();
         wait_drained();
      end
      no_idling = 1'b0;
   endtask

   // The result side refuses everything for a long stretch while vectors keep
   // coming, so the pipeline fills and must stall its input without loss.
   task automatic test_output_backpressure();
      program_matrix(random_matrix(2));
      no_idling       = 1'b1;
      rsp_hold_cycles = 150;
      repeat (60)
         send_random_vector();
      wait_drained();
      no_idling = 1'b0;
   endtask

   // The sender stops after each burst until every result is back, so the
   // pipeline empties completely between bursts.
   task automatic test_sender_pause();
      program_matrix(random_matrix(0));
      repeat (3) begin
         repeat (20)
            send_random_vector();
         wait_drained();
      end
   endtask

   initial begin
      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_bus.valid = 1'b0;
      req_bus.vec_x = '0;
      req_bus.vec_y = '0;
      req_bus.vec_z = '0;
      req_bus.vec_w = '0;
      rsp_bus.ready = 1'b0;

      // Identity, as the block holds it after reset.
      matrix_regs = fill_matrix('0);
      matrix_regs[mvt_pkg::REG_ROW0_COLS01] = {32'h0, mvt_pkg::ELEM_ONE};
      matrix_regs[mvt_pkg::REG_ROW1_COLS01] = {mvt_pkg::ELEM_ONE, 32'h0};
      matrix_regs[mvt_pkg::REG_ROW2_COLS23] = {32'h0, mvt_pkg::ELEM_ONE};
      matrix_regs[mvt_pkg::REG_ROW3_COLS23] = {mvt_pkg::ELEM_ONE, 32'h0};

      repeat (7)
         @(posedge clock);
      reset <= 1'b0;

      test_identity_after_reset();
      test_saturation_extremes();
      test_rounding_boundaries();
      test_random_matrices();
      test_output_backpressure();
      test_sender_pause();

      wait_drained();
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
